// File: hw/rtl/cfh_pkg.sv
// Shared types, constants and the CRC-32 byte update for the command frame handler.
`timescale 1ns / 1ps

package cfh_pkg;

	localparam int NUM_STEPPERS = 8;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	// receive parser phases
	typedef enum logic [3:0] {
		PH_HUNT,
		PH_ID,
		PH_INSTR,
		PH_STEP,
		PH_REG,
		PH_DATA,
		PH_CRC,
		PH_END
	} cfh_phase_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_START     = 3'd0,
		CFG_END       = 3'd1,
		CFG_DEVICE_ID = 3'd2,
		CFG_PRESENT   = 3'd3,
		CFG_OPCODES   = 3'd4,
		CFG_VALIDITY  = 3'd5
	} cfh_cfg_idx_t;

	// byte slots of a reply frame
	typedef logic [3:0] cfh_slot_t;
	localparam cfh_slot_t SLOT_START = 4'd0;
	localparam cfh_slot_t SLOT_ID    = 4'd1;
	localparam cfh_slot_t SLOT_VAL   = 4'd2;
	localparam cfh_slot_t SLOT_RES0  = 4'd3;
	localparam cfh_slot_t SLOT_RES1  = 4'd4;
	localparam cfh_slot_t SLOT_RES2  = 4'd5;
	localparam cfh_slot_t SLOT_RES3  = 4'd6;
	localparam cfh_slot_t SLOT_CRC0  = 4'd7;
	localparam cfh_slot_t SLOT_CRC1  = 4'd8;
	localparam cfh_slot_t SLOT_CRC2  = 4'd9;
	localparam cfh_slot_t SLOT_CRC3  = 4'd10;
	localparam cfh_slot_t SLOT_END   = 4'd11;

	typedef struct packed {
		logic [7:0]  sof_code;
		logic [7:0]  eof_code;
		logic [7:0]  node_id;
		logic [7:0]  stepper_present;
		logic [31:0] opcode_codes;
		logic [15:0] validity_codes;
	} cfh_cfg_t;

	// one command from parser to reply/request generator
	typedef struct packed {
		logic        is_req;
		logic        req_write;
		logic [7:0]  validity;
		logic [31:0] word;
		logic [7:0]  stepper;
		logic [7:0]  regaddr;
	} cfh_cmd_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] r;
		r = c ^ {24'h000000, b};
		for (int i = 0; i < 8; i++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/cfh_front.sv
// Receive parser: frame hunting, field capture, CRC check and command classification.
`timescale 1ns / 1ps

module cfh_front (
	input  logic              clk,
	input  logic              arst_n,
	input  cfh_pkg::cfh_cfg_t cfg,
	input  logic              acc,
	input  logic              kind,
	input  logic [7:0]        rx_byte,
	input  logic [31:0]       stepper_result,
	output logic              push,
	output cfh_pkg::cfh_cmd_t cmd
);

	cfh_pkg::cfh_phase_t phase_q, phase_d;
	logic [1:0]  cnt_q;
	logic [7:0]  instr_q;
	logic [7:0]  stepper_q;
	logic [7:0]  regaddr_q;
	logic [31:0] data_q;
	logic [23:0] rcrc_q;
	logic [31:0] crc_q;
	logic        awaiting_q;

	logic        byte_acc;
	logic        crc_ok;
	logic        is_read, is_write, is_sys, present;
	logic [7:0]  good_code, bad_code;

	assign byte_acc  = acc && !kind && !awaiting_q;
	assign crc_ok    = {rcrc_q, rx_byte} == ~crc_q;
	assign good_code = cfg.validity_codes[7:0];
	assign bad_code  = cfg.validity_codes[15:8];

	assign is_read  = instr_q == cfg.opcode_codes[7:0];
	assign is_write = !is_read && instr_q == cfg.opcode_codes[15:8];
	assign is_sys   = instr_q == cfg.opcode_codes[23:16] || instr_q == cfg.opcode_codes[31:24];
	assign present  = stepper_q < 8'(cfh_pkg::NUM_STEPPERS) && stepper_q < 8'd8
		&& cfg.stepper_present[stepper_q[2:0]];

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (byte_acc) begin
			unique case (phase_q)
				cfh_pkg::PH_HUNT:  if (rx_byte == cfg.sof_code) phase_d = cfh_pkg::PH_ID;
				cfh_pkg::PH_ID:    phase_d = (rx_byte == cfg.node_id) ? cfh_pkg::PH_INSTR
				                                                      : cfh_pkg::PH_HUNT;
				cfh_pkg::PH_INSTR: phase_d = cfh_pkg::PH_STEP;
				cfh_pkg::PH_STEP:  phase_d = cfh_pkg::PH_REG;
				cfh_pkg::PH_REG:   phase_d = cfh_pkg::PH_DATA;
				cfh_pkg::PH_DATA:  if (cnt_q == 2'd3) phase_d = cfh_pkg::PH_CRC;
				cfh_pkg::PH_CRC: begin
					if (cnt_q == 2'd3) phase_d = crc_ok ? cfh_pkg::PH_END : cfh_pkg::PH_HUNT;
				end
				cfh_pkg::PH_END:   phase_d = cfh_pkg::PH_HUNT;
				default:           phase_d = cfh_pkg::PH_HUNT;
			endcase
		end
	end

	// command issue
	always_comb begin
		push          = 1'b0;
		cmd           = '0;
		cmd.stepper   = stepper_q;
		cmd.regaddr   = regaddr_q;
		if (acc && awaiting_q && kind) begin
			push         = 1'b1;
			cmd          = '0;
			cmd.validity = good_code;
			cmd.word     = stepper_result;
		end else if (byte_acc && phase_q == cfh_pkg::PH_END && rx_byte == cfg.eof_code) begin
			push = 1'b1;
			if ((is_read || is_write) && present) begin
				cmd.is_req    = 1'b1;
				cmd.req_write = is_write;
				cmd.word      = is_write ? data_q : 32'h0;
			end else begin
				cmd          = '0;
				cmd.validity = (is_sys && !is_read && !is_write) ? good_code : bad_code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= cfh_pkg::PH_HUNT;
			cnt_q      <= 2'd0;
			instr_q    <= 8'h00;
			stepper_q  <= 8'h00;
			regaddr_q  <= 8'h00;
			data_q     <= 32'h0;
			rcrc_q     <= 24'h0;
			crc_q      <= cfh_pkg::CRC_INIT;
			awaiting_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (acc && awaiting_q && kind) begin
				awaiting_q <= 1'b0;
			end else if (push && cmd.is_req) begin
				awaiting_q <= 1'b1;
			end
			if (byte_acc) begin
				case (phase_q)
					cfh_pkg::PH_INSTR: instr_q <= rx_byte;
					cfh_pkg::PH_STEP:  stepper_q <= rx_byte;
					cfh_pkg::PH_REG: begin
						regaddr_q <= rx_byte;
						data_q    <= 32'h0;
						crc_q     <= cfh_pkg::CRC_INIT;
						cnt_q     <= 2'd0;
					end
					cfh_pkg::PH_DATA: begin
						data_q <= {data_q[23:0], rx_byte};
						crc_q  <= cfh_pkg::crc_byte(crc_q, rx_byte);
						cnt_q  <= cnt_q + 2'd1;
						if (cnt_q == 2'd3) rcrc_q <= 24'h0;
					end
					cfh_pkg::PH_CRC: begin
						rcrc_q <= {rcrc_q[15:0], rx_byte};
						cnt_q  <= cnt_q + 2'd1;
					end
					default: ;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	// while a stepper answer is outstanding the parser sits in hunt
	assert property (@(posedge clk) disable iff (!arst_n)
		awaiting_q |-> phase_q == cfh_pkg::PH_HUNT)
		else $error("parser left hunt while awaiting a stepper result");
	// received bytes never issue anything while a result is outstanding
	assert property (@(posedge clk) disable iff (!arst_n)
		(awaiting_q && acc && !kind) |-> !push)
		else $error("command issued from a byte while awaiting a result");
	// a request always leaves the parser waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && cmd.is_req) |=> awaiting_q)
		else $error("request issued without entering the wait");
`endif

endmodule

// File: hw/rtl/cfh_queue.sv
// Short command queue between parser and reply/request generator.
`timescale 1ns / 1ps

module cfh_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cfh_pkg::cfh_cmd_t push_cmd,
	input  logic              pop,
	output cfh_pkg::cfh_cmd_t head,
	output logic              empty,
	output logic              full
);

	localparam int D = cfh_pkg::QUEUE_DEPTH;

	cfh_pkg::cfh_cmd_t              mem_q [D];
	logic [cfh_pkg::QPTR_W-1:0]     wr_q, rd_q;
	logic [cfh_pkg::QCNT_W-1:0]     cnt_q;
	logic                           do_push, do_pop;

	assign empty   = cnt_q == '0;
	assign full    = cnt_q == cfh_pkg::QCNT_W'(D);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= (wr_q == cfh_pkg::QPTR_W'(D - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)  rd_q <= (rd_q == cfh_pkg::QPTR_W'(D - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cfh_pkg::QCNT_W'(D))
		else $error("queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");
	assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("pop from empty queue");
`endif

endmodule

// File: hw/rtl/cfh_back.sv
// Reply frame and stepper request generator with CRC over the result word.
`timescale 1ns / 1ps

module cfh_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cfh_pkg::cfh_cfg_t cfg,
	input  cfh_pkg::cfh_cmd_t head,
	input  logic              empty,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [63:0]       m_tdata,
	output logic              m_tuser,
	output logic              m_tlast
);

	cfh_pkg::cfh_cmd_t  cmd_q;
	cfh_pkg::cfh_slot_t idx_q;
	logic [31:0]        crc_q;
	logic               busy_q;

	logic               xfer, done;
	logic [7:0]         res_byte;
	logic [7:0]         tx_byte;
	logic [31:0]        crc_out;

	assign xfer    = busy_q && m_tready;
	assign done    = xfer && (cmd_q.is_req || idx_q == cfh_pkg::SLOT_END);
	assign pop     = !empty && (!busy_q || done);
	assign crc_out = ~crc_q;

	always_comb begin
		case (idx_q)
			cfh_pkg::SLOT_RES0: res_byte = cmd_q.word[31:24];
			cfh_pkg::SLOT_RES1: res_byte = cmd_q.word[23:16];
			cfh_pkg::SLOT_RES2: res_byte = cmd_q.word[15:8];
			default:            res_byte = cmd_q.word[7:0];
		endcase
	end

	always_comb begin
		case (idx_q)
			cfh_pkg::SLOT_START: tx_byte = cfg.sof_code;
			cfh_pkg::SLOT_ID:    tx_byte = cfg.node_id;
			cfh_pkg::SLOT_VAL:   tx_byte = cmd_q.validity;
			cfh_pkg::SLOT_CRC0:  tx_byte = crc_out[31:24];
			cfh_pkg::SLOT_CRC1:  tx_byte = crc_out[23:16];
			cfh_pkg::SLOT_CRC2:  tx_byte = crc_out[15:8];
			cfh_pkg::SLOT_CRC3:  tx_byte = crc_out[7:0];
			cfh_pkg::SLOT_END:   tx_byte = cfg.eof_code;
			default:             tx_byte = res_byte;
		endcase
	end

	assign m_tvalid = busy_q;
	assign m_tuser  = cmd_q.is_req;
	assign m_tlast  = !cmd_q.is_req && idx_q == cfh_pkg::SLOT_END;
	assign m_tdata  = cmd_q.is_req
		? {7'h00, cmd_q.word, cmd_q.regaddr, cmd_q.stepper, cmd_q.req_write, 8'h00}
		: {56'h0, tx_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= cfh_pkg::SLOT_START;
			crc_q  <= cfh_pkg::CRC_INIT;
			cmd_q  <= '0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				cmd_q  <= head;
				idx_q  <= cfh_pkg::SLOT_START;
				crc_q  <= cfh_pkg::CRC_INIT;
			end else if (done) begin
				busy_q <= 1'b0;
			end else if (xfer) begin
				idx_q <= idx_q + 4'd1;
				// CRC follows the result bytes as they go out
				if (idx_q inside {[cfh_pkg::SLOT_RES0:cfh_pkg::SLOT_RES3]}) begin
					crc_q <= cfh_pkg::crc_byte(crc_q, res_byte);
				end
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= cfh_pkg::SLOT_END)
		else $error("reply slot out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cmd_q.is_req) |-> idx_q == cfh_pkg::SLOT_START)
		else $error("request advanced past its single transfer");
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !m_tready) |=> busy_q && $stable(idx_q))
		else $error("output moved while stalled");
`endif

endmodule

// File: hw/rtl/crc32_command_frame_handler_core.sv
// Top level: configuration registers, parser front, command queue, reply back end.
`timescale 1ns / 1ps

//  channel  | dir | handshake          | payload
//  ---------+-----+--------------------+-----------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tuser: kind; tdata: rx_byte, stepper_result
//  m_       | out | m_tvalid/m_tready  | tuser: out_kind; tlast: last; tdata: request/reply
//  cfg_     | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One input item per cycle when not stalled; each is parsed in the cycle it is taken.
// A reply leaves as 12 transfers, a stepper request as one; the back end starts the
// next command in the cycle after the previous one's final transfer.
// A two-entry command queue separates parser and back end; the input stalls only
// when that queue is full. Asynchronous active-low reset; no clearing pass.

module crc32_command_frame_handler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] rx_byte, [39:8] stepper_result
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [7:0] tx_byte, [8] req_write, [16:9] req_stepper,
	                               // [24:17] req_register, [56:25] req_data, rest zero
	output logic        m_tuser,   // [0] out_kind
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfh_pkg::cfh_cfg_t cfg_q;
	cfh_pkg::cfh_cmd_t push_cmd, head;
	logic              push, pop, empty, full, acc;

	assign cfg_ready = 1'b1;
	assign s_tready  = !full;
	assign acc       = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sof_code        <= 8'hAA;
			cfg_q.eof_code        <= 8'h55;
			cfg_q.node_id         <= 8'h01;
			cfg_q.stepper_present <= 8'h00;
			cfg_q.opcode_codes    <= 32'h04030201;
			cfg_q.validity_codes  <= 16'h0100;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cfh_pkg::CFG_START:     cfg_q.sof_code        <= cfg_data[7:0];
				cfh_pkg::CFG_END:       cfg_q.eof_code        <= cfg_data[7:0];
				cfh_pkg::CFG_DEVICE_ID: cfg_q.node_id         <= cfg_data[7:0];
				cfh_pkg::CFG_PRESENT:   cfg_q.stepper_present <= cfg_data[7:0];
				cfh_pkg::CFG_OPCODES:   cfg_q.opcode_codes    <= cfg_data;
				cfh_pkg::CFG_VALIDITY:  cfg_q.validity_codes  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	cfh_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.acc            (acc),
		.kind           (s_tuser),
		.rx_byte        (s_tdata[7:0]),
		.stepper_result (s_tdata[39:8]),
		.push           (push),
		.cmd            (push_cmd)
	);

	cfh_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	cfh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
